[rtl/vslpf_pkg.sv]
// Shared types and constants for the variable-step low-pass filter.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vslpf_pkg;

  localparam int unsigned TAU_W   = 27;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned GAP_W   = 32;

  localparam logic [TAU_W-1:0] TAU_RESET = TAU_W'(1000);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // capture an input word
    logic seed;      // accepted word reseeds the filter
    logic gap;       // form the time gap and the difference
    logic prep;      // set up the divider
    logic div_step;  // one quotient bit
    logic mul;       // weight times difference
    logic upd;       // add the step to the held value
    logic out_load;  // move the held value into the output register
  } vslpf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic seed_path; // the offered word starts a series or is the first since reset
  } vslpf_sts_t;

endpackage

`default_nettype wire

[rtl/variable_step_low_pass_filter.sv]
// Top level of the variable-step low-pass filter.
// Depends on vslpf_pkg, vslpf_ctrl and vslpf_datapath.
//
// Smooths timestamped Q16.16 samples with a first-order low-pass whose
// weight gap/(tau+gap) follows the time between samples. A sample that
// starts a series (or the first after reset) is passed through to the
// output register. Any other sample is accepted, then goes through the gap,
// divider setup, restoring divider (one weight bit per cycle), multiply,
// update and output steps. One sample is worked on at a time; the next is
// taken as soon as the previous result has moved into the output register,
// even while that result is stalled. The time constant is written through
// cfg_valid/cfg_ready; the user must write it only while idle, which the
// block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module variable_step_low_pass_filter #(
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [vslpf_pkg::TAU_W-1:0]          time_constant_ms,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  start_series,
  input  wire  [vslpf_pkg::TIME_W-1:0]         sample_time_ms,
  input  wire  signed [vslpf_pkg::VALUE_W-1:0] sample_value,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [vslpf_pkg::VALUE_W-1:0] filtered_value
);

  vslpf_pkg::vslpf_cmd_t cmd;
  vslpf_pkg::vslpf_sts_t sts;

  // Register writes are taken at once
  assign cfg_ready = 1'b1;

  vslpf_ctrl #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vslpf_datapath #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid),
    .time_constant_ms(time_constant_ms),
    .start_series    (start_series),
    .sample_time_ms  (sample_time_ms),
    .sample_value    (sample_value),
    .filtered_value  (filtered_value)
  );

endmodule

`default_nettype wire

[rtl/vslpf_ctrl.sv]
// Controller state machine for the variable-step low-pass filter.
// Depends on vslpf_pkg; drives commands into vslpf_datapath.
`timescale 1ns / 1ps
`default_nettype none

module vslpf_ctrl #(
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  vslpf_pkg::vslpf_sts_t sts,
  output vslpf_pkg::vslpf_cmd_t cmd
);

  localparam int unsigned CNT_W = $clog2(WEIGHT_FRAC_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WEIGHT_FRAC_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_OUT
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Decode commands from the current state
  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.seed     = accept && sts.seed_path;
    cmd.gap      = (state == ST_GAP);
    cmd.prep     = (state == ST_PREP);
    cmd.div_step = (state == ST_DIV);
    cmd.mul      = (state == ST_MUL);
    cmd.upd      = (state == ST_UPD);
    cmd.out_load = (state == ST_OUT) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = sts.seed_path ? ST_OUT : ST_GAP;
        end
      end
      ST_GAP:  state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state, divider count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/vslpf_datapath.sv]
// Datapath of the variable-step low-pass filter: gap, restoring divider,
// multiplier and held value. Depends on vslpf_pkg; commanded by vslpf_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module vslpf_datapath #(
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  vslpf_pkg::vslpf_cmd_t                 cmd,
  output vslpf_pkg::vslpf_sts_t                 sts,
  input  wire                                   cfg_valid,
  input  wire  [vslpf_pkg::TAU_W-1:0]           time_constant_ms,
  input  wire                                   start_series,
  input  wire  [vslpf_pkg::TIME_W-1:0]          sample_time_ms,
  input  wire  signed [vslpf_pkg::VALUE_W-1:0]  sample_value,
  output logic signed [vslpf_pkg::VALUE_W-1:0]  filtered_value
);

  localparam int unsigned F      = WEIGHT_FRAC_BITS;
  localparam int unsigned TIME_W = vslpf_pkg::TIME_W;
  localparam int unsigned VAL_W  = vslpf_pkg::VALUE_W;
  localparam int unsigned GAP_W  = vslpf_pkg::GAP_W;
  localparam int unsigned DEN_W  = GAP_W + 1;
  localparam int unsigned REM_W  = GAP_W + 2;
  localparam int unsigned PROD_W = F + 2 + VAL_W + 1;

  logic [vslpf_pkg::TAU_W-1:0] tau;
  logic [TIME_W-1:0]           last_time;
  logic                        seeded;
  logic signed [VAL_W-1:0]     held;
  logic [TIME_W-1:0]           t_r;
  logic signed [VAL_W-1:0]     x_r;
  logic [GAP_W-1:0]            gap;
  logic signed [VAL_W:0]       diff;
  logic [DEN_W-1:0]            den;
  logic [REM_W-1:0]            rem;
  logic [F-1:0]                quot;
  logic signed [PROD_W-1:0]    prod;

  logic [TIME_W-1:0]           elapsed;
  logic [GAP_W-1:0]            gap_next;
  logic [REM_W-1:0]            rem_shift;
  logic                        fits;
  logic [F:0]                  weight;
  logic signed [PROD_W-1:0]    prod_next;
  logic signed [PROD_W-1:0]    step_full;
  logic signed [VAL_W-1:0]     held_next;

  assign sts.seed_path = start_series || !seeded;

  // Clamp the gap: backward time gives zero, long gaps saturate
  assign elapsed  = t_r - last_time;
  always_comb begin
    if (t_r < last_time) begin
      gap_next = '0;
    end else if (|elapsed[TIME_W-1:GAP_W]) begin
      gap_next = '1;
    end else begin
      gap_next = elapsed[GAP_W-1:0];
    end
  end

  // One restoring division step
  assign rem_shift = {rem[REM_W-2:0], 1'b0};
  assign fits      = (rem_shift >= {1'b0, den});

  // Weight of one when tau is zero
  assign weight    = (tau == '0) ? {1'b1, {F{1'b0}}} : {1'b0, quot};
  assign prod_next = $signed({1'b0, weight}) * diff;

  // Floor shift of the product, then move the held value
  assign step_full = prod >>> F;
  assign held_next = held + $signed(step_full[VAL_W-1:0]);

  // Control state: register, timestamp, seed flag and held value
  always_ff @(posedge clk) begin
    if (rst) begin
      tau       <= vslpf_pkg::TAU_RESET;
      last_time <= '0;
      seeded    <= 1'b0;
      held      <= '0;
    end else begin
      if (cfg_valid) begin
        tau <= time_constant_ms;
      end
      if (cmd.seed) begin
        held      <= sample_value;
        last_time <= sample_time_ms;
        seeded    <= 1'b1;
      end else begin
        if (cmd.gap) begin
          last_time <= t_r;
        end
        if (cmd.upd) begin
          held <= held_next;
        end
      end
    end
  end

  // Working registers of the datapath
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r <= sample_time_ms;
      x_r <= sample_value;
    end
    if (cmd.gap) begin
      gap  <= gap_next;
      diff <= $signed({x_r[VAL_W-1], x_r}) - $signed({held[VAL_W-1], held});
    end
    if (cmd.prep) begin
      den  <= {{(DEN_W - vslpf_pkg::TAU_W){1'b0}}, tau} + {1'b0, gap};
      rem  <= {2'b00, gap};
      quot <= '0;
    end
    if (cmd.div_step) begin
      rem  <= fits ? (rem_shift - {1'b0, den}) : rem_shift;
      quot <= {quot[F-2:0], fits};
    end
    if (cmd.mul) begin
      prod <= prod_next;
    end
    if (cmd.out_load) begin
      filtered_value <= held;
    end
  end

endmodule

`default_nettype wire

[rtl/vslpf_checker.sv]
// Port-level checks for the variable-step low-pass filter, bound to the
// top level. Depends on vslpf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module vslpf_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 cfg_valid,
  input wire                                 cfg_ready,
  input wire                                 in_valid,
  input wire                                 in_stall,
  input wire                                 start_series,
  input wire signed [vslpf_pkg::VALUE_W-1:0] sample_value,
  input wire                                 out_valid,
  input wire                                 out_stall,
  input wire signed [vslpf_pkg::VALUE_W-1:0] filtered_value
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_value))
    else $error("stalled result word changed");

  // One word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a word is in flight");

  // No result word straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word valid after reset");

  // A series start passes through unchanged when the output is free
  a_seed_pass: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && start_series && !out_valid
    |=> ##1 out_valid && (filtered_value == $past(sample_value, 2)))
    else $error("series start did not pass through");

  // Register writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write refused");

endmodule

bind variable_step_low_pass_filter vslpf_checker u_vslpf_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .start_series  (start_series),
  .sample_value  (sample_value),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .filtered_value(filtered_value)
);

`default_nettype wire
